[design/bclr_pkg.sv]
// ----------------------------------------------------------------------------
// bclr_pkg
// Codes, control word layout and microprogram of the rotating leader detector.
// ----------------------------------------------------------------------------
package bclr_pkg;

   localparam int RANK_W  = 5;
   localparam int ROUND_W = 32;
   localparam int UPC_W   = 4;

   // request kinds (req_tuser)
   localparam logic [1:0] REQ_RX       = 2'd0;
   localparam logic [1:0] REQ_LOCAL    = 2'd1;
   localparam logic [1:0] REQ_ANNOUNCE = 2'd2;

   // result kinds (rsp_tuser)
   localparam logic [1:0] KIND_STATUS = 2'd0;
   localparam logic [1:0] KIND_SEND   = 2'd1;
   localparam logic [1:0] KIND_TRUST  = 2'd2;

   // complaint status
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_ROUND = 2'd1;
   localparam logic [1:0] ST_DUP   = 2'd2;
   localparam logic [1:0] ST_RANK  = 2'd3;

   // register indexes
   localparam logic [1:0] REG_OWN_RANK    = 2'd0;
   localparam logic [1:0] REG_PEER_TOTAL  = 2'd1;
   localparam logic [1:0] REG_FAULT_BOUND = 2'd2;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_LATCH,
      OP_CHECK,
      OP_BC_INIT,
      OP_BC_STEP,
      OP_BC_DONE,
      OP_ADVANCE,
      OP_DIV_INIT,
      OP_DIV_STEP,
      OP_LEADER,
      OP_TRUST
   } op_type;

   typedef enum logic [3:0] {
      C_NEXT,
      C_ALWAYS,
      C_LOCAL,
      C_ANNOUNCE,
      C_NOT_RX,
      C_NO_BC,
      C_BC_MORE,
      C_NO_ADV,
      C_DIV_MORE
   } cond_type;

   typedef struct packed {
      op_type            op;
      cond_type          cond;
      logic [UPC_W-1:0]  target;
   } ctrl_type;

   // microprogram step addresses
   localparam logic [UPC_W-1:0] U_FETCH    = 4'd0;
   localparam logic [UPC_W-1:0] U_IS_LOCAL = 4'd1;
   localparam logic [UPC_W-1:0] U_IS_ANN   = 4'd2;
   localparam logic [UPC_W-1:0] U_IS_RX    = 4'd3;
   localparam logic [UPC_W-1:0] U_CHECK    = 4'd4;
   localparam logic [UPC_W-1:0] U_BC_TEST  = 4'd5;
   localparam logic [UPC_W-1:0] U_BC_INIT  = 4'd6;
   localparam logic [UPC_W-1:0] U_BC_STEP  = 4'd7;
   localparam logic [UPC_W-1:0] U_BC_DONE  = 4'd8;
   localparam logic [UPC_W-1:0] U_ADV_TEST = 4'd9;
   localparam logic [UPC_W-1:0] U_ADVANCE  = 4'd10;
   localparam logic [UPC_W-1:0] U_DIV_INIT = 4'd11;
   localparam logic [UPC_W-1:0] U_DIV_STEP = 4'd12;
   localparam logic [UPC_W-1:0] U_LEADER   = 4'd13;
   localparam logic [UPC_W-1:0] U_TRUST    = 4'd14;

   function automatic ctrl_type ucode_rom(input logic [UPC_W-1:0] addr);
      ctrl_type w;
      case (addr)
         U_FETCH:    w = '{OP_LATCH,    C_NEXT,     U_FETCH};
         U_IS_LOCAL: w = '{OP_NONE,     C_LOCAL,    U_BC_INIT};
         U_IS_ANN:   w = '{OP_NONE,     C_ANNOUNCE, U_DIV_INIT};
         U_IS_RX:    w = '{OP_NONE,     C_NOT_RX,   U_FETCH};
         U_CHECK:    w = '{OP_CHECK,    C_NEXT,     U_FETCH};
         U_BC_TEST:  w = '{OP_NONE,     C_NO_BC,    U_ADV_TEST};
         U_BC_INIT:  w = '{OP_BC_INIT,  C_NEXT,     U_FETCH};
         U_BC_STEP:  w = '{OP_BC_STEP,  C_BC_MORE,  U_BC_STEP};
         U_BC_DONE:  w = '{OP_BC_DONE,  C_NEXT,     U_FETCH};
         U_ADV_TEST: w = '{OP_NONE,     C_NO_ADV,   U_FETCH};
         U_ADVANCE:  w = '{OP_ADVANCE,  C_NEXT,     U_FETCH};
         U_DIV_INIT: w = '{OP_DIV_INIT, C_NEXT,     U_FETCH};
         U_DIV_STEP: w = '{OP_DIV_STEP, C_DIV_MORE, U_DIV_STEP};
         U_LEADER:   w = '{OP_LEADER,   C_NEXT,     U_FETCH};
         U_TRUST:    w = '{OP_TRUST,    C_ALWAYS,   U_FETCH};
         default:    w = '{OP_NONE,     C_ALWAYS,   U_FETCH};
      endcase
      return w;
   endfunction

endpackage

[design/byzantine_complaint_leader_rotation_unit.sv]
// ----------------------------------------------------------------------------
// byzantine_complaint_leader_rotation_unit
// Rotating leader detector: checks complaints, broadcasts, advances rounds.
// ----------------------------------------------------------------------------
//  channel | dir | handshake              | payload
//  req     | in  | req_tvalid/req_tready  | tuser type, tdata rank+round
//  rsp     | out | rsp_tvalid/rsp_tready  | tuser kind, tdata, tlast
//  csr     | in  | APB psel/penable       | own_rank, peer_total, fault_bound
//
//  One word at a time through a microcoded sequencer. A complaint that only
//  returns its status is the shortest path, a broadcast adds a scan over the ranks
//  scanned (the peer count, at most 15 when own rank is outside the peers),
//  a round advance adds the 32-step remainder loop. An announce word runs the
//  remainder loop alone, a local complain the broadcast scan alone.
//  Synchronous reset. A stalled rsp holds the sequencer on its emit step.
// ----------------------------------------------------------------------------
module byzantine_complaint_leader_rotation_unit #(
   parameter int MAX_PEERS = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [39:0]  req_tdata,   // sender_rank[4:0], claim_round[36:5]
   input  logic [1:0]   req_tuser,   // req_type[1:0]
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [39:0]  rsp_tdata,   // status[1:0], target_rank[6:2], out_round[38:7]
   output logic [1:0]   rsp_tuser,   // out_kind[1:0]
   output logic         rsp_tlast,
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [3:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);

   localparam int PW = $clog2(MAX_PEERS + 1);
   localparam int CW = (PW > bclr_pkg::RANK_W) ? PW : bclr_pkg::RANK_W;
   localparam int MW = MAX_PEERS;

   // configuration
   logic [4:0] own_ff, peer_ff;
   logic [2:0] fb_ff;

   // sequencer
   logic [bclr_pkg::UPC_W-1:0] upc_ff, upc_in;
   bclr_pkg::ctrl_type         cw;

   // latched request
   logic [1:0]  rtype_ff, rtype_in;
   logic [4:0]  sender_ff, sender_in;
   logic [31:0] claim_ff, claim_in;

   // protocol state
   logic [31:0]   round_ff, round_in;
   logic          compl_ff, compl_in;
   logic [MW-1:0] map_ff, map_in;
   logic [4:0]    count_ff, count_in;
   logic [4:0]    leader_ff, leader_in;
   logic          bc_pend_ff, bc_pend_in;
   logic          adv_pend_ff, adv_pend_in;

   // work registers
   logic [CW-1:0] idx_ff, idx_in;
   logic [CW-1:0] sent_ff, sent_in;
   logic [CW-1:0] rem_ff, rem_in;
   logic [4:0]    divcnt_ff, divcnt_in;

   // output register
   logic        ovalid_ff, ovalid_in;
   logic [1:0]  okind_ff, okind_in;
   logic [1:0]  ost_ff, ost_in;
   logic [4:0]  otgt_ff, otgt_in;
   logic [31:0] oround_ff, oround_in;
   logic        olast_ff, olast_in;

   logic          out_busy, emit, hold, jump;
   logic [CW-1:0] npeers, own_x, snd_x, s_dec, nxt;
   logic [MW-1:0] map_bit;
   logic          bad, dup, bc_emit, bc_more, more_send;
   logic [1:0]    st;
   logic [4:0]    cnt_inc;
   logic          bc_will, adv_will;
   logic [CW:0]   div_sh;
   logic [1:0]    e_kind, e_st;
   logic [4:0]    e_tgt;
   logic [31:0]   e_round;
   logic          e_last;
   logic          wr;

   assign cw = bclr_pkg::ucode_rom(upc_ff);

   assign npeers = (peer_ff == 5'd0) ? CW'(1) :
                   (CW'(peer_ff) > CW'(MAX_PEERS)) ? CW'(MAX_PEERS) : CW'(peer_ff);
   assign own_x  = CW'(own_ff);
   assign snd_x  = CW'(sender_ff);
   assign s_dec  = snd_x - CW'(1);

   assign map_bit = MW'(1) << s_dec;
   assign bad     = (sender_ff == 5'd0) || (snd_x > npeers) || (sender_ff == own_ff);
   assign dup     = |(map_ff & map_bit);
   assign st      = bad ? bclr_pkg::ST_RANK :
                    (claim_ff != round_ff) ? bclr_pkg::ST_ROUND :
                    dup ? bclr_pkg::ST_DUP : bclr_pkg::ST_OK;
   assign cnt_inc  = count_ff + 5'd1;
   assign bc_will  = (st == bclr_pkg::ST_OK) && (cnt_inc > 5'(fb_ff)) && !compl_ff;
   assign adv_will = (st == bclr_pkg::ST_OK) && (cnt_inc > 5'({fb_ff, 1'b0}));

   assign bc_emit = (idx_ff <= npeers) && (idx_ff != own_x) && (sent_ff < CW'(MAX_PEERS - 1));

   assign div_sh = {rem_ff, round_ff[divcnt_ff]};

   assign out_busy = ovalid_ff && !rsp_tready;
   assign emit = (cw.op == bclr_pkg::OP_CHECK) || (cw.op == bclr_pkg::OP_TRUST) ||
                 ((cw.op == bclr_pkg::OP_BC_STEP) && bc_emit);
   assign hold = (emit && out_busy) || ((cw.op == bclr_pkg::OP_LATCH) && !req_tvalid);

   assign req_tready = (cw.op == bclr_pkg::OP_LATCH);

   // datapath
   always_comb begin
      rtype_in    = rtype_ff;
      sender_in   = sender_ff;
      claim_in    = claim_ff;
      round_in    = round_ff;
      compl_in    = compl_ff;
      map_in      = map_ff;
      count_in    = count_ff;
      leader_in   = leader_ff;
      bc_pend_in  = bc_pend_ff;
      adv_pend_in = adv_pend_ff;
      idx_in      = idx_ff;
      sent_in     = sent_ff;
      rem_in      = rem_ff;
      divcnt_in   = divcnt_ff;
      e_kind      = bclr_pkg::KIND_STATUS;
      e_st        = bclr_pkg::ST_OK;
      e_tgt       = 5'd0;
      e_round     = round_ff;
      e_last      = 1'b0;
      nxt         = '0;
      more_send   = 1'b0;
      if (!hold) begin
         case (cw.op)
            bclr_pkg::OP_LATCH: begin
               rtype_in    = req_tuser;
               sender_in   = req_tdata[4:0];
               claim_in    = req_tdata[36:5];
               bc_pend_in  = 1'b0;
               adv_pend_in = 1'b0;
            end
            bclr_pkg::OP_CHECK: begin
               e_st        = st;
               e_tgt       = sender_ff;
               e_last      = !(bc_will || adv_will);
               bc_pend_in  = bc_will;
               adv_pend_in = adv_will;
               if (st == bclr_pkg::ST_OK) begin
                  map_in   = map_ff | map_bit;
                  count_in = cnt_inc;
               end
            end
            bclr_pkg::OP_BC_INIT: begin
               idx_in  = CW'(1);
               sent_in = '0;
            end
            bclr_pkg::OP_BC_STEP: begin
               idx_in = idx_ff + CW'(1);
               if (bc_emit) begin
                  sent_in = sent_ff + CW'(1);
               end
               nxt       = (idx_in == own_x) ? idx_in + CW'(1) : idx_in;
               more_send = (nxt <= npeers) && (sent_in < CW'(MAX_PEERS - 1));
               e_kind    = bclr_pkg::KIND_SEND;
               e_tgt     = idx_ff[4:0];
               e_last    = !more_send && !adv_pend_ff;
            end
            bclr_pkg::OP_BC_DONE: begin
               compl_in = 1'b1;
            end
            bclr_pkg::OP_ADVANCE: begin
               round_in = round_ff + 32'd1;
               compl_in = 1'b0;
               map_in   = '0;
               count_in = 5'd0;
            end
            bclr_pkg::OP_DIV_INIT: begin
               rem_in    = '0;
               divcnt_in = 5'd31;
            end
            bclr_pkg::OP_DIV_STEP: begin
               rem_in    = (div_sh >= {1'b0, npeers}) ? CW'(div_sh - {1'b0, npeers})
                                                      : CW'(div_sh);
               divcnt_in = divcnt_ff - 5'd1;
            end
            bclr_pkg::OP_LEADER: begin
               leader_in = 5'(rem_ff + CW'(1));
            end
            bclr_pkg::OP_TRUST: begin
               e_kind = bclr_pkg::KIND_TRUST;
               e_tgt  = leader_ff;
               e_last = 1'b1;
            end
            default: begin
            end
         endcase
      end
   end

   // sequencing
   always_comb begin
      case (cw.cond)
         bclr_pkg::C_NEXT:     jump = 1'b0;
         bclr_pkg::C_ALWAYS:   jump = 1'b1;
         bclr_pkg::C_LOCAL:    jump = (rtype_ff == bclr_pkg::REQ_LOCAL);
         bclr_pkg::C_ANNOUNCE: jump = (rtype_ff == bclr_pkg::REQ_ANNOUNCE);
         bclr_pkg::C_NOT_RX:   jump = (rtype_ff != bclr_pkg::REQ_RX);
         bclr_pkg::C_NO_BC:    jump = !bc_pend_ff;
         bclr_pkg::C_BC_MORE:  jump = (idx_in <= npeers) && (sent_in < CW'(MAX_PEERS - 1));
         bclr_pkg::C_NO_ADV:   jump = !adv_pend_ff;
         bclr_pkg::C_DIV_MORE: jump = (divcnt_ff != 5'd0);
         default:              jump = 1'b1;
      endcase
      if (hold) begin
         upc_in = upc_ff;
      end else if (jump) begin
         upc_in = cw.target;
      end else begin
         upc_in = upc_ff + 1'b1;
      end
   end

   // output register
   always_comb begin
      ovalid_in = ovalid_ff;
      okind_in  = okind_ff;
      ost_in    = ost_ff;
      otgt_in   = otgt_ff;
      oround_in = oround_ff;
      olast_in  = olast_ff;
      if (emit && !out_busy) begin
         ovalid_in = 1'b1;
         okind_in  = e_kind;
         ost_in    = e_st;
         otgt_in   = e_tgt;
         oround_in = e_round;
         olast_in  = e_last;
      end else if (rsp_tready) begin
         ovalid_in = 1'b0;
      end
   end

   assign wr = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         own_ff      <= 5'd1;
         peer_ff     <= 5'd4;
         fb_ff       <= 3'd1;
         upc_ff      <= bclr_pkg::U_FETCH;
         round_ff    <= '0;
         compl_ff    <= 1'b0;
         map_ff      <= '0;
         count_ff    <= '0;
         leader_ff   <= 5'd1;
         bc_pend_ff  <= 1'b0;
         adv_pend_ff <= 1'b0;
         ovalid_ff   <= 1'b0;
      end else begin
         if (wr) begin
            case (csr_paddr[3:2])
               bclr_pkg::REG_OWN_RANK:    own_ff  <= csr_pwdata[4:0];
               bclr_pkg::REG_PEER_TOTAL:  peer_ff <= csr_pwdata[4:0];
               bclr_pkg::REG_FAULT_BOUND: fb_ff   <= csr_pwdata[2:0];
               default: begin
               end
            endcase
         end
         upc_ff      <= upc_in;
         round_ff    <= round_in;
         compl_ff    <= compl_in;
         map_ff      <= map_in;
         count_ff    <= count_in;
         leader_ff   <= leader_in;
         bc_pend_ff  <= bc_pend_in;
         adv_pend_ff <= adv_pend_in;
         ovalid_ff   <= ovalid_in;
      end
   end

   always_ff @(posedge clock) begin
      rtype_ff  <= rtype_in;
      sender_ff <= sender_in;
      claim_ff  <= claim_in;
      idx_ff    <= idx_in;
      sent_ff   <= sent_in;
      rem_ff    <= rem_in;
      divcnt_ff <= divcnt_in;
      okind_ff  <= okind_in;
      ost_ff    <= ost_in;
      otgt_ff   <= otgt_in;
      oround_ff <= oround_in;
      olast_ff  <= olast_in;
   end

   always_comb begin
      case (csr_paddr[3:2])
         bclr_pkg::REG_OWN_RANK:    csr_prdata = {27'd0, own_ff};
         bclr_pkg::REG_PEER_TOTAL:  csr_prdata = {27'd0, peer_ff};
         bclr_pkg::REG_FAULT_BOUND: csr_prdata = {29'd0, fb_ff};
         default:                   csr_prdata = 32'd0;
      endcase
   end

   assign csr_pready = 1'b1;
   assign rsp_tvalid = ovalid_ff;
   assign rsp_tuser  = okind_ff;
   assign rsp_tlast  = olast_ff;
   assign rsp_tdata  = {1'b0, oround_ff, otgt_ff, ost_ff};

endmodule

[sim/tb_byzantine_complaint_leader_rotation_unit.sv]
// ----------------------------------------------------------------------------
// tb_byzantine_complaint_leader_rotation_unit
// Self-checking bench for the rotating leader detector. Drives received
// complaints, local complain, announce and unknown-type words, keeps its own copy of the
// detector state to work out every rsp word, and checks rsp words in order
// under random stalls on both streams and several register settings.
// ----------------------------------------------------------------------------
module tb_byzantine_complaint_leader_rotation_unit;

   localparam int MAX_PEERS   = 16;
   localparam int HOLD_CYCLES = 200;
   localparam int SETTLE      = 64;
   localparam int WATCHDOG    = 2000;
   localparam logic [1:0] REQ_UNKNOWN = 2'd3;

   typedef struct packed {
      logic [1:0]  kind;
      logic [1:0]  status;
      logic [4:0]  target;
      logic [31:0] round;
      logic        last;
   } result_word_type;

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_tvalid  = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata   = '0;
   logic [1:0]  req_tuser   = '0;
   logic        rsp_tvalid;
   logic        rsp_tready  = 1'b0;
   logic [39:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        rsp_tlast;
   logic        csr_psel    = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite  = 1'b0;
   logic [3:0]  csr_paddr   = '0;
   logic [31:0] csr_pwdata  = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   // detector copy
   logic [4:0]  cfg_own_rank    = 5'd1;
   logic [4:0]  cfg_peer_total  = 5'd4;
   logic [2:0]  cfg_fault_bound = 3'd1;
   logic [31:0] cur_round       = '0;
   logic        complained      = 1'b0;
   logic [15:0] complainer_bits = '0;
   int          accepted_count  = 0;
   logic [4:0]  leader          = 5'd1;

   result_word_type due_results[$];
   result_word_type step_words[$];
   int  mismatches    = 0;
   bit  no_idle       = 1'b0;
   bit  rsp_hold_req  = 1'b0;
   int  rsp_hold_left = 0;

   byzantine_complaint_leader_rotation_unit #(
      .MAX_PEERS(MAX_PEERS)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .rsp_tlast(rsp_tlast),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic int eff_peers();
      int p;
      p = int'(cfg_peer_total);
      if (p < 1) p = 1;
      if (p > MAX_PEERS) p = MAX_PEERS;
      return p;
   endfunction

   task automatic push_word(input logic [1:0] kind, input logic [1:0] st,
                            input logic [4:0] target, input logic [31:0] rnd);
      result_word_type w;
      w = {kind, st, target, rnd, 1'b0};
      step_words.push_back(w);
   endtask

   task automatic add_complaints();
      int n;
      int sent;
      n = eff_peers();
      sent = 0;
      for (int i = 1; i <= n && sent < MAX_PEERS - 1; i++) begin
         if (5'(i) != cfg_own_rank) begin
            push_word(bclr_pkg::KIND_SEND, bclr_pkg::ST_OK, 5'(i), cur_round);
            sent++;
         end
      end
      complained = 1'b1;
   endtask

   task automatic add_trust();
      leader = 5'((cur_round % 32'(eff_peers())) + 32'd1);
      push_word(bclr_pkg::KIND_TRUST, bclr_pkg::ST_OK, leader, cur_round);
   endtask

   // expected rsp words of one accepted req word
   task automatic detector_step(input logic [1:0] kind, input logic [4:0] rank,
                                input logic [31:0] rnd);
      logic [1:0] st;
      step_words.delete();
      case (kind)
         bclr_pkg::REQ_RX: begin
            if (rank == 5'd0 || int'(rank) > eff_peers() || rank == cfg_own_rank)
               st = bclr_pkg::ST_RANK;
            else if (rnd != cur_round)
               st = bclr_pkg::ST_ROUND;
            else if (complainer_bits[int'(rank) - 1])
               st = bclr_pkg::ST_DUP;
            else
               st = bclr_pkg::ST_OK;
            push_word(bclr_pkg::KIND_STATUS, st, rank, cur_round);
            if (st == bclr_pkg::ST_OK) begin
               complainer_bits[int'(rank) - 1] = 1'b1;
               accepted_count++;
               if (accepted_count > int'(cfg_fault_bound) && !complained)
                  add_complaints();
               if (accepted_count > 2 * int'(cfg_fault_bound)) begin
                  cur_round       = cur_round + 32'd1;
                  complained      = 1'b0;
                  complainer_bits = '0;
                  accepted_count  = 0;
                  add_trust();
               end
            end
         end
         bclr_pkg::REQ_LOCAL:    add_complaints();
         bclr_pkg::REQ_ANNOUNCE: add_trust();
         default: ;
      endcase
      if (step_words.size() > 0) step_words[step_words.size() - 1].last = 1'b1;
      foreach (step_words[k]) due_results.push_back(step_words[k]);
   endtask

   task automatic send_word(input logic [1:0] kind, input logic [4:0] rank,
                            input logic [31:0] rnd);
      int gap;
      gap = 0;
      if (!no_idle && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 5);
      repeat (gap) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {3'b000, rnd, rank};
      do @(posedge clock); while (!req_tready);
      detector_step(kind, rank, rnd);
   endtask

   function automatic logic [4:0] pick_peer();
      int n;
      logic [4:0] r;
      n = eff_peers();
      r = 5'($urandom_range(1, n));
      for (int k = 0; k < 8 && r == cfg_own_rank; k++) r = 5'($urandom_range(1, n));
      return r;
   endfunction

   // mostly well-formed complaints for the current round, the rest noise
   task automatic send_mixed_word();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 72)
         send_word(bclr_pkg::REQ_RX, pick_peer(), cur_round);
      else if (pick < 80)
         send_word(bclr_pkg::REQ_LOCAL, 5'($urandom_range(0, 16)), $urandom);
      else if (pick < 86)
         send_word(bclr_pkg::REQ_ANNOUNCE, 5'($urandom_range(0, 16)), $urandom);
      else if (pick < 89)
         send_word(REQ_UNKNOWN, 5'($urandom_range(0, 31)), $urandom);
      else if (pick < 95)
         send_word(bclr_pkg::REQ_RX, 5'($urandom_range(0, 16)), cur_round);
      else
         send_word(bclr_pkg::REQ_RX, pick_peer(), $urandom);
   endtask

   task automatic drain_results();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (due_results.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic csr_write(input logic [1:0] idx, input logic [31:0] value);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      case (idx)
         bclr_pkg::REG_OWN_RANK:    cfg_own_rank    = value[4:0];
         bclr_pkg::REG_PEER_TOTAL:  cfg_peer_total  = value[4:0];
         bclr_pkg::REG_FAULT_BOUND: cfg_fault_bound = value[2:0];
         default: ;
      endcase
   endtask

   task automatic set_config(input int own, input int peers, input int bound);
      drain_results();
      csr_write(bclr_pkg::REG_OWN_RANK, 32'(own));
      csr_write(bclr_pkg::REG_PEER_TOTAL, 32'(peers));
      csr_write(bclr_pkg::REG_FAULT_BOUND, 32'(bound));
   endtask

   // reset settings: rank checks, round check, duplicate, broadcast, advance
   task automatic test_reset_settings();
      send_word(bclr_pkg::REQ_ANNOUNCE, 5'd0, 32'd0);
      send_word(bclr_pkg::REQ_RX, 5'd0, 32'd0);
      send_word(bclr_pkg::REQ_RX, 5'd1, 32'd0);
      send_word(bclr_pkg::REQ_RX, 5'd5, 32'd0);
      send_word(bclr_pkg::REQ_RX, 5'd16, 32'hFFFF_FFFF);
      send_word(bclr_pkg::REQ_RX, 5'd2, 32'hFFFF_FFFF);
      send_word(bclr_pkg::REQ_RX, 5'd2, cur_round);
      send_word(bclr_pkg::REQ_RX, 5'd2, cur_round);
      send_word(bclr_pkg::REQ_RX, 5'd3, cur_round);
      send_word(REQ_UNKNOWN, 5'd31, 32'hFFFF_FFFF);
      send_word(bclr_pkg::REQ_RX, 5'd4, cur_round);
      send_word(bclr_pkg::REQ_LOCAL, 5'd16, 32'hFFFF_FFFF);
      send_word(bclr_pkg::REQ_RX, 5'd3, 32'd0);
   endtask

   task automatic test_register_extremes();
      // zero bound, flag set: first complaint only advances, the next one
      // broadcasts to fifteen peers and advances
      set_config(16, 16, 0);
      send_word(bclr_pkg::REQ_RX, 5'd15, cur_round);
      send_word(bclr_pkg::REQ_RX, 5'd15, cur_round);
      send_word(bclr_pkg::REQ_ANNOUNCE, 5'd1, 32'd0);
      // own rank outside the peers, peer count clamped from above
      set_config(0, 31, 5);
      send_word(bclr_pkg::REQ_LOCAL, 5'd0, 32'd0);
      send_word(bclr_pkg::REQ_RX, 5'd16, cur_round);
      // peer count clamped from below: local complain with nobody to tell
      set_config(1, 0, 0);
      send_word(bclr_pkg::REQ_LOCAL, 5'd0, 32'd0);
      send_word(bclr_pkg::REQ_RX, 5'd1, cur_round);
      send_word(bclr_pkg::REQ_ANNOUNCE, 5'd0, 32'd0);
      // flag still set: first advance without broadcast, second with
      set_config(2, 2, 0);
      send_word(bclr_pkg::REQ_RX, 5'd1, cur_round);
      send_word(bclr_pkg::REQ_RX, 5'd1, cur_round);
   endtask

   task automatic test_random_settings();
      int own_set[8];
      int peer_set[8];
      int bound_set[8];
      own_set   = '{3, 16, 1, 5, 2, 9, 0, 1};
      peer_set  = '{7, 16, 4, 16, 2, 12, 16, 10};
      bound_set = '{2, 5, 1, 0, 0, 3, 4, 4};
      for (int p = 0; p < 8; p++) begin
         set_config(own_set[p], peer_set[p], bound_set[p]);
         repeat (27) send_mixed_word();
      end
   endtask

   task automatic test_rsp_backpressure();
      rsp_hold_req = 1'b1;
      repeat (20) send_mixed_word();
   endtask

   task automatic test_no_idle_tail();
      set_config(4, 9, 2);
      no_idle = 1'b1;
      repeat (30) send_mixed_word();
   endtask

   // rsp sink: random stalls and one long hold-off on request
   always @(negedge clock) begin
      if (rsp_hold_left > 0) begin
         rsp_tready <= 1'b0;
         rsp_hold_left--;
      end else if (rsp_hold_req) begin
         rsp_hold_req  = 1'b0;
         rsp_hold_left = HOLD_CYCLES - 1;
         rsp_tready    <= 1'b0;
      end else if (!no_idle && $urandom_range(0, 7) == 0) begin
         rsp_hold_left = $urandom_range(0, 4);
         rsp_tready    <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      result_word_type got;
      result_word_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = {rsp_tuser, rsp_tdata[1:0], rsp_tdata[6:2], rsp_tdata[38:7], rsp_tlast};
         if (due_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected rsp word: kind %0d st %0d tgt %0d rnd %0h last %0d",
                        got.kind, got.status, got.target, got.round, got.last);
         end else begin
            want = due_results.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("mismatch: want kind %0d st %0d tgt %0d rnd %0h last %0d",
                           want.kind, want.status, want.target, want.round, want.last);
                  $display("          got  kind %0d st %0d tgt %0d rnd %0h last %0d",
                           got.kind, got.status, got.target, got.round, got.last);
               end
            end
         end
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_psel && csr_penable))
            quiet = 0;
         else
            quiet++;
      end
      $display("CHECK FAILED");
      $finish;
   end

   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_reset_settings();
      test_register_extremes();
      test_random_settings();
      test_rsp_backpressure();
      test_no_idle_tail();
      drain_results();
      mismatches += due_results.size();
      if (mismatches == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
